// ===== rtl/ifg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ifg_pkg
// Shared constants for the interferogram pixel pipeline.
// ----------------------------------------------------------------------------
package ifg_pkg;

	// width of one I or Q part of a radar sample
	localparam int unsigned SAMPLE_BITS_DEF = 16;

endpackage : ifg_pkg
`default_nettype wire

// ===== rtl/interferogram_pixel.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// interferogram_pixel
// Conjugate multiply of two complex radar samples plus the amplitude of each.
//
// A pixel pair is taken on every clock edge where start is high; busy stays
// low, so one transaction may be issued every cycle. The result appears on
// phase_re, phase_im, first_mag and second_mag once it has passed the product,
// sum and square root stages, marked by done for exactly one cycle.
// Throughput is one pixel per cycle: the products take one stage, the sums
// one stage, and the square root one stage per root bit.
// phase_re = first_re*second_re + first_im*second_im
// phase_im = first_im*second_re - first_re*second_im
// first_mag, second_mag = floor(sqrt(re^2 + im^2)) of each sample.
// Reset clears only the valid pipeline, so no done strobe is seen until new
// transactions drain through. The receiver cannot stall; results must be
// captured in the cycle done is high.
// ----------------------------------------------------------------------------
module interferogram_pixel #(
	parameter int unsigned SAMPLE_BITS = ifg_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic signed [SAMPLE_BITS-1:0]   first_re,
	input  wire logic signed [SAMPLE_BITS-1:0]   first_im,
	input  wire logic signed [SAMPLE_BITS-1:0]   second_re,
	input  wire logic signed [SAMPLE_BITS-1:0]   second_im,
	output logic                                 done,
	output logic signed [2*SAMPLE_BITS:0]        phase_re,
	output logic signed [2*SAMPLE_BITS:0]        phase_im,
	output logic        [SAMPLE_BITS-1:0]        first_mag,
	output logic        [SAMPLE_BITS-1:0]        second_mag
);
	import ifg_pkg::*;

	localparam int unsigned PW    = 2 * SAMPLE_BITS;
	localparam int unsigned DEPTH = SAMPLE_BITS + 2;

	logic                 accept;
	logic [DEPTH-1:0]     vld_s;

	logic signed [PW-1:0] p_rr_s1, p_ii_s1, p_ir_s1, p_ri_s1;
	logic signed [PW-1:0] sq_ar_s1, sq_ai_s1, sq_br_s1, sq_bi_s1;

	logic signed [PW:0]   phase_re_s2, phase_im_s2;
	logic [PW-1:0]        pow_a_s2, pow_b_s2;

	// phase results wait alongside the square root stages
	logic signed [PW:0]   phase_re_s [SAMPLE_BITS];
	logic signed [PW:0]   phase_im_s [SAMPLE_BITS];

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[DEPTH-2:0], accept};
		end
	end

	always_ff @(posedge clk) begin
		p_rr_s1  <= first_re * second_re;
		p_ii_s1  <= first_im * second_im;
		p_ir_s1  <= first_im * second_re;
		p_ri_s1  <= first_re * second_im;
		sq_ar_s1 <= first_re * first_re;
		sq_ai_s1 <= first_im * first_im;
		sq_br_s1 <= second_re * second_re;
		sq_bi_s1 <= second_im * second_im;
	end

	// squares are never negative, so the power sum fits PW bits unsigned
	always_ff @(posedge clk) begin
		phase_re_s2 <= {p_rr_s1[PW-1], p_rr_s1} + {p_ii_s1[PW-1], p_ii_s1};
		phase_im_s2 <= {p_ir_s1[PW-1], p_ir_s1} - {p_ri_s1[PW-1], p_ri_s1};
		pow_a_s2    <= $unsigned(sq_ar_s1) + $unsigned(sq_ai_s1);
		pow_b_s2    <= $unsigned(sq_br_s1) + $unsigned(sq_bi_s1);
	end

	for (genvar k = 0; k < SAMPLE_BITS; k++) begin : g_delay
		if (k == 0) begin : g_first
			always_ff @(posedge clk) begin
				phase_re_s[k] <= phase_re_s2;
				phase_im_s[k] <= phase_im_s2;
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				phase_re_s[k] <= phase_re_s[k-1];
				phase_im_s[k] <= phase_im_s[k-1];
			end
		end
	end

	ifg_sqrt #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_sqrt_first (
		.clk  (clk),
		.rad  (pow_a_s2),
		.root (first_mag)
	);

	ifg_sqrt #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_sqrt_second (
		.clk  (clk),
		.rad  (pow_b_s2),
		.root (second_mag)
	);

	assign done     = vld_s[DEPTH-1];
	assign phase_re = phase_re_s[SAMPLE_BITS-1];
	assign phase_im = phase_im_s[SAMPLE_BITS-1];

endmodule : interferogram_pixel
`default_nettype wire

// ===== rtl/ifg_sqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ifg_sqrt
// Pipelined integer square root, one root bit per register stage. Takes a
// 2*SAMPLE_BITS-bit radicand every cycle and gives floor(sqrt) from the
// last stage.
// ----------------------------------------------------------------------------
module ifg_sqrt #(
	parameter int unsigned SAMPLE_BITS = ifg_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic [2*SAMPLE_BITS-1:0]   rad,
	output logic      [SAMPLE_BITS-1:0]     root
);
	import ifg_pkg::*;

	localparam int unsigned RW = 2 * SAMPLE_BITS;
	localparam int unsigned W  = SAMPLE_BITS + 2;

	// partial remainder, root so far and unconsumed radicand bits per stage
	logic [W-1:0]           rem_s  [SAMPLE_BITS-1];
	logic [RW-1:0]          rad_s  [SAMPLE_BITS-1];
	logic [SAMPLE_BITS-1:0] root_s [SAMPLE_BITS];

	for (genvar k = 0; k < SAMPLE_BITS; k++) begin : g_stage
		logic [W-1:0]           rem_in;
		logic [W-1:0]           rem_sh;
		logic [W-1:0]           trial;
		logic [SAMPLE_BITS-1:0] root_in;
		logic [RW-1:0]          rad_in;
		logic                   ge;

		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = rad;
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign rad_in  = rad_s[k-1];
		end

		// bring down the next two radicand bits, try root*4+1
		assign rem_sh = {rem_in[W-3:0], rad_in[RW-1:RW-2]};
		assign trial  = {root_in, 2'b01};
		assign ge     = (rem_sh >= trial);

		always_ff @(posedge clk) begin
			root_s[k] <= {root_in[SAMPLE_BITS-2:0], ge};
		end

		if (k < SAMPLE_BITS - 1) begin : g_carry
			always_ff @(posedge clk) begin
				rem_s[k] <= ge ? (rem_sh - trial) : rem_sh;
				rad_s[k] <= {rad_in[RW-3:0], 2'b00};
			end
		end
	end

	assign root = root_s[SAMPLE_BITS-1];

endmodule : ifg_sqrt
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for interferogram_pixel. A short table of directed
// pixel pairs (zero, full-scale, most negative, unit vectors) is followed by
// random pairs with random gaps on the start side. Every transaction is
// predicted in the bench and compared field by field against the done strobe.
// ----------------------------------------------------------------------------
module testbench;

	localparam int unsigned SB = ifg_pkg::SAMPLE_BITS_DEF;
	localparam int RANDOM_PIXELS = 1950;
	localparam int DRAIN_CYCLES = 2 * SB + 20;

	typedef logic signed [SB-1:0] part_t;
	typedef logic signed [2*SB:0] phase_t;
	typedef logic [SB-1:0] mag_t;

	typedef struct {
		phase_t phase_re;
		phase_t phase_im;
		mag_t   first_mag;
		mag_t   second_mag;
	} pixel_t;

	// one directed row; known marks rows whose result is typed in
	typedef struct {
		longint fr, fi, sr, si;
		bit     known;
		longint pre, pim, fmag, smag;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	part_t first_re, first_im, second_re, second_im;
	logic done;
	phase_t phase_re, phase_im;
	mag_t first_mag, second_mag;

	pixel_t expected_pixels[$];
	int mismatch_count = 0;

	stim_row_t directed_rows[16] = '{
		'{0, 0, 0, 0, 1, 0, 0, 0, 0},
		'{-32768, -32768, -32768, -32768, 1, 64'sd2147483648, 0, 46340, 46340},
		'{32767, 32767, 32767, 32767, 1, 64'sd2147352578, 0, 46339, 46339},
		'{-32768, 0, 0, 32767, 1, 0, 64'sd1073709056, 32768, 32767},
		'{3, 4, 0, 0, 1, 0, 0, 5, 0},
		'{0, 0, -4, 3, 1, 0, 0, 0, 5},
		'{32767, -32768, -32768, 32767, 0, 0, 0, 0, 0},
		'{1, 0, 1, 0, 0, 0, 0, 0, 0},
		'{0, 1, 0, 1, 0, 0, 0, 0, 0},
		'{1, 0, 0, 1, 0, 0, 0, 0, 0},
		'{0, 1, 1, 0, 0, 0, 0, 0, 0},
		'{-1, -1, -1, -1, 0, 0, 0, 0, 0},
		'{21845, -21846, -21846, 21845, 0, 0, 0, 0, 0},
		'{-32768, 32767, 32767, -32768, 0, 0, 0, 0, 0},
		'{-32768, -32768, 32767, 32767, 0, 0, 0, 0, 0},
		'{12345, -23456, -1, 32767, 0, 0, 0, 0, 0}
	};

	interferogram_pixel #(
		.SAMPLE_BITS(SB)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.first_re   (first_re),
		.first_im   (first_im),
		.second_re  (second_re),
		.second_im  (second_im),
		.done       (done),
		.phase_re   (phase_re),
		.phase_im   (phase_im),
		.first_mag  (first_mag),
		.second_mag (second_mag)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// floor square root, one trial bit at a time from the top
	function automatic mag_t floor_root(input longint unsigned power);
		longint unsigned root;
		longint unsigned trial;
		root = 0;
		for (int b = SB - 1; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= power)
				root = trial;
		end
		return mag_t'(root);
	endfunction

	function automatic pixel_t conj_product(input part_t fr, fi, sr, si);
		longint a_re, a_im, b_re, b_im;
		pixel_t p;
		a_re = fr;
		a_im = fi;
		b_re = sr;
		b_im = si;
		p.phase_re   = phase_t'(a_re * b_re + a_im * b_im);
		p.phase_im   = phase_t'(a_im * b_re - a_re * b_im);
		p.first_mag  = floor_root(a_re * a_re + a_im * a_im);
		p.second_mag = floor_root(b_re * b_re + b_im * b_im);
		return p;
	endfunction

	function automatic part_t pick_part();
		case ($urandom_range(9))
			0: return {1'b1, {(SB-1){1'b0}}};
			1: return {1'b0, {(SB-1){1'b1}}};
			2: return '0;
			3: return part_t'($signed($urandom_range(0, 14)) - 7);
			default: return part_t'($urandom);
		endcase
	endfunction

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	task automatic send_pixel(input part_t fr, fi, sr, si, input bit known, input pixel_t typed);
		first_re  <= fr;
		first_im  <= fi;
		second_re <= sr;
		second_im <= si;
		start     <= 1'b1;
		do @(posedge clk); while (busy);
		expected_pixels.push_back(known ? typed : conj_product(fr, fi, sr, si));
	endtask

	// start low for a while; mostly short, now and then long
	task automatic hold_off(input bit gaps_on);
		int unsigned r;
		int unsigned n;
		r = $urandom_range(99);
		if (!gaps_on || r < 60)
			n = 0;
		else if (r < 90)
			n = $urandom_range(1, 3);
		else if (r < 98)
			n = $urandom_range(4, 10);
		else
			n = $urandom_range(20, 60);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// results cannot be held off, so every done cycle is a transaction
	always @(posedge clk) begin
		pixel_t want;
		if (arst_n && done) begin
			if (expected_pixels.size() == 0) begin
				$display("%0t: unexpected result, phase_re %0d phase_im %0d", $time,
					phase_re, phase_im);
				mismatch_count++;
			end else begin
				want = expected_pixels.pop_front();
				check_field("phase_re", longint'(want.phase_re), longint'(phase_re));
				check_field("phase_im", longint'(want.phase_im), longint'(phase_im));
				check_field("first_mag", longint'(want.first_mag), longint'(first_mag));
				check_field("second_mag", longint'(want.second_mag), longint'(second_mag));
			end
		end
	end

	initial begin
		pixel_t typed;
		bit gaps_on;
		arst_n    = 1'b0;
		start     = 1'b0;
		first_re  = '0;
		first_im  = '0;
		second_re = '0;
		second_im = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			typed.phase_re   = phase_t'(directed_rows[i].pre);
			typed.phase_im   = phase_t'(directed_rows[i].pim);
			typed.first_mag  = mag_t'(directed_rows[i].fmag);
			typed.second_mag = mag_t'(directed_rows[i].smag);
			send_pixel(part_t'(directed_rows[i].fr), part_t'(directed_rows[i].fi),
				part_t'(directed_rows[i].sr), part_t'(directed_rows[i].si),
				directed_rows[i].known, typed);
			hold_off(i % 5 == 2);
		end

		gaps_on = 1'b1;
		for (int n = 0; n < RANDOM_PIXELS; n++) begin
			// stretches of back-to-back or gappy traffic, chosen at random
			if (n % 150 == 0)
				gaps_on = $urandom_range(2) != 0;
			send_pixel(pick_part(), pick_part(), pick_part(), pick_part(), 1'b0, typed);
			hold_off(gaps_on);
		end
		start <= 1'b0;

		wait (expected_pixels.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("[interferogram_pixel] OK");
		else
			$display("[interferogram_pixel] ERROR");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("%0t: timeout, %0d results outstanding", $time, expected_pixels.size());
		$display("[interferogram_pixel] ERROR");
		$finish;
	end

endmodule
